[rtl/core/lca_pkg.sv]
// Package for the lux calculator with automatic gain ranging.
// Holds payload structs, fixed-point constants and table functions.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lca_pkg;

    localparam int LUX_FRAC_BITS = 8;
    localparam int CNT_W         = 16;
    localparam int GAIN_W        = 2;
    localparam int ITIME_W       = 3;
    localparam int STATUS_W      = 2;
    localparam int LUX_W         = 28;
    localparam int MAG_W         = 27;
    localparam int M_W           = MAG_W + 1;
    localparam int DF_W          = 9;
    localparam int PROD_W        = MAG_W + DF_W;
    localparam int WIDE_W        = PROD_W + LUX_FRAC_BITS;
    localparam int NUM_W         = WIDE_W - 10;
    localparam int DEN_W         = 23;
    localparam int DCNT_W        = $clog2(NUM_W);
    localparam int QX_W          = (NUM_W > LUX_W + 1) ? NUM_W : LUX_W + 1;

    localparam logic [CNT_W-1:0]    SAT_COUNT  = 16'hFFFF;
    localparam logic [DF_W-1:0]     LUX_DF     = 9'd408;
    localparam int                  COEF_B_Q10 = 1679;
    localparam int                  COEF_C_Q10 = 604;
    localparam int                  COEF_D_Q10 = 881;
    localparam logic [ITIME_W-1:0]  ITIME_RESET = 3'd5;
    localparam logic [GAIN_W-1:0]   GAIN_MAX   = 2'd3;
    localparam logic [GAIN_W-1:0]   GAIN_MIN   = 2'd0;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RETRY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] full_count;
        logic [CNT_W-1:0] ir_count;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [LUX_W-1:0] lux_q8;
        logic [CNT_W-1:0]        visible_count;
        logic [GAIN_W-1:0]       gain_used;
        logic [GAIN_W-1:0]       next_gain;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic prod;
        logic diff;
        logic scale;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sat;
        logic div_last;
        logic out_busy;
    } stat_t;

    function automatic logic [9:0] atime_ms(input logic [ITIME_W-1:0] sel);
        logic [9:0] ms;
        case (sel)
            3'd0:    ms = 10'd100;
            3'd1:    ms = 10'd200;
            3'd2:    ms = 10'd300;
            3'd3:    ms = 10'd400;
            3'd4:    ms = 10'd500;
            3'd5:    ms = 10'd600;
            default: ms = 10'd100;
        endcase
        return ms;
    endfunction

    function automatic logic [13:0] gain_factor(input logic [GAIN_W-1:0] g);
        logic [13:0] f;
        case (g)
            2'd0:    f = 14'd1;
            2'd1:    f = 14'd25;
            2'd2:    f = 14'd428;
            default: f = 14'd9876;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lca_ctrl.sv]
// Sequencer for the lux calculator: steps one measurement word through
// products, scaling, serial division and output. Depends on lca_pkg.
`default_nettype none

module lca_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  lca_pkg::stat_t     stat,
    output lca_pkg::cmd_t      cmd
);
    import lca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_DIFF, S_SCALE, S_DINIT, S_DIV, S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = stat.sat ? S_DONE : S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lca_datapath.sv]
// Datapath for the lux calculator: gain state, integration time register,
// coefficient products, restoring divider and output register. Uses lca_pkg.
`default_nettype none

module lca_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  lca_pkg::cmd_t                  cmd,
    output lca_pkg::stat_t                 stat,
    input  lca_pkg::in_word_t              s_data,
    input  wire logic                      cfg_valid,
    input  wire logic [lca_pkg::ITIME_W-1:0] cfg_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output lca_pkg::out_word_t             m_data
);
    import lca_pkg::*;

    logic [ITIME_W-1:0]  itime_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                m_valid_reg;
    out_word_t           out_reg;

    logic [CNT_W-1:0]    full_reg, ir_reg;
    logic                sat_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    vis_reg;
    logic [GAIN_W-1:0]   used_reg, next_gain_reg;

    logic [MAG_W-1:0]    pa_reg, pb_reg, pc_reg, pd_reg;
    logic                neg_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DCNT_W-1:0]   dcnt_reg;

    logic                in_sat;
    logic [GAIN_W-1:0]   load_next_gain;
    logic [STATUS_W-1:0] load_status;
    logic signed [M_W-1:0] l1, l2, m_sel, m_abs;
    logic [WIDE_W-1:0]   wide;
    logic [DEN_W:0]      trial;
    logic                take;
    logic [QX_W-1:0]     qx;
    logic [LUX_W-1:0]    lux_val;

    always_comb begin
        in_sat = (s_data.full_count == SAT_COUNT) || (s_data.ir_count == SAT_COUNT);
        if (in_sat && gain_reg != GAIN_MIN) begin
            load_status    = STATUS_RETRY;
            load_next_gain = gain_reg - 1'b1;
        end else if (in_sat) begin
            load_status    = STATUS_FAIL;
            load_next_gain = GAIN_MAX;
        end else begin
            load_status    = STATUS_OK;
            load_next_gain = GAIN_MAX;
        end
    end

    always_comb begin
        l1    = $signed({1'b0, pa_reg}) - $signed({1'b0, pb_reg});
        l2    = $signed({1'b0, pc_reg}) - $signed({1'b0, pd_reg});
        m_sel = (l1 > l2) ? l1 : l2;
        m_abs = m_sel[M_W-1] ? -m_sel : m_sel;
        wide  = WIDE_W'(prod_reg) << LUX_FRAC_BITS;
        trial = {rem_reg, quo_reg[NUM_W-1]};
        take  = (trial >= {1'b0, den_reg});
        qx    = QX_W'(quo_reg);
        if (neg_reg) begin
            if (qx > (QX_W'(1) << (LUX_W - 1))) begin
                lux_val = {1'b1, {(LUX_W-1){1'b0}}};
            end else begin
                lux_val = -qx[LUX_W-1:0];
            end
        end else begin
            if (qx > ((QX_W'(1) << (LUX_W - 1)) - QX_W'(1))) begin
                lux_val = {1'b0, {(LUX_W-1){1'b1}}};
            end else begin
                lux_val = qx[LUX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            itime_reg   <= ITIME_RESET;
            gain_reg    <= GAIN_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                itime_reg <= cfg_data;
            end
            if (cmd.load) begin
                gain_reg <= load_next_gain;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            full_reg      <= s_data.full_count;
            ir_reg        <= s_data.ir_count;
            sat_reg       <= in_sat;
            status_reg    <= load_status;
            used_reg      <= gain_reg;
            next_gain_reg <= load_next_gain;
            vis_reg       <= (s_data.full_count > s_data.ir_count) ?
                             s_data.full_count - s_data.ir_count : '0;
        end
        if (cmd.prod) begin
            pa_reg <= MAG_W'({full_reg, 10'b0});
            pb_reg <= MAG_W'(COEF_B_Q10) * MAG_W'(ir_reg);
            pc_reg <= MAG_W'(COEF_C_Q10) * MAG_W'(full_reg);
            pd_reg <= MAG_W'(COEF_D_Q10) * MAG_W'(ir_reg);
        end
        if (cmd.diff) begin
            neg_reg <= m_sel[M_W-1];
            mag_reg <= m_abs[MAG_W-1:0];
        end
        if (cmd.scale) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(LUX_DF);
            den_reg  <= DEN_W'(atime_ms(itime_reg)) * DEN_W'(gain_factor(used_reg));
        end
        if (cmd.div_init) begin
            rem_reg  <= '0;
            quo_reg  <= wide[WIDE_W-1:10];
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg  <= {quo_reg[NUM_W-2:0], take};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            out_reg.status        <= status_reg;
            out_reg.lux_q8        <= sat_reg ? '0 : lux_val;
            out_reg.visible_count <= vis_reg;
            out_reg.gain_used     <= used_reg;
            out_reg.next_gain     <= next_gain_reg;
        end
    end

    assign stat.sat      = sat_reg;
    assign stat.div_last = (dcnt_reg == DCNT_W'(NUM_W - 1));
    assign stat.out_busy = m_valid_reg && !m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;

endmodule

`default_nettype wire

[rtl/core/lux_calc_autogain_top.sv]
// Top level of the lux calculator with automatic gain ranging.
// Joins lca_ctrl and lca_datapath; uses lca_pkg for word types.
//
//   channel | ports                      | word
//   --------+----------------------------+------------------------------
//   input   | s_valid s_ready s_data     | full_count, ir_count
//   result  | m_valid m_ready m_data     | status, lux_q8, visible_count,
//           |                            | gain_used, next_gain
//   config  | cfg_valid cfg_ready cfg_data | integration_time, always ready
//
// A valid measurement runs load, products, difference, scaling, divider setup
// and a one-bit-per-cycle restoring divider; a saturated word skips to output.
// One word is in flight at a time; the next is taken once the result sits
// in the output register. Reset sets gain to maximum and integration time
// to 600 ms. A stalled result holds the sequencer before the output stage.
`default_nettype none

module lux_calc_autogain_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  lca_pkg::in_word_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lca_pkg::out_word_t               m_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lca_pkg::ITIME_W-1:0] cfg_data
);
    import lca_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    lca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lca_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[rtl/core/lca_checker.sv]
// Port-level checks for lux_calc_autogain_top, attached by bind.
// Uses lca_pkg status and gain codes.
`default_nettype none

module lca_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input lca_pkg::out_word_t      m_data
);
    import lca_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_lux_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.lux_q8 == '0)
        else $error("lux nonzero on saturated result");

    a_retry_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_RETRY |->
            m_data.gain_used != GAIN_MIN && m_data.next_gain == m_data.gain_used - 1'b1)
        else $error("retry does not step gain down");

    a_gain_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_RETRY |-> m_data.next_gain == GAIN_MAX &&
            (m_data.status != STATUS_FAIL || m_data.gain_used == GAIN_MIN))
        else $error("gain not restored to maximum");

endmodule

bind lux_calc_autogain_top lca_checker u_lca_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
